### design/sdle_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdle_pkg
// Shared types and constants for the slot directory with least-active evict.
// ----------------------------------------------------------------------------
package sdle_pkg;

	localparam int SLOTS_DEF = 16;

	localparam logic FUNC_LOOKUP     = 1'b0;
	localparam logic FUNC_INVALIDATE = 1'b1;

	typedef struct packed {
		logic        func;
		logic [31:0] relation_id;
		logic [63:0] group_key_hash;
	} in_t;

	typedef struct packed {
		logic [3:0]  slot_index;
		logic        is_new;
		logic        hit;
		logic        evicted;
		logic [4:0]  occupancy;
		logic [31:0] hit_total;
		logic [31:0] miss_total;
		logic [31:0] eviction_total;
	} out_t;

	// one directory entry as held in the memory
	typedef struct packed {
		logic [31:0] relation;
		logic [63:0] hash;
		logic [31:0] activity;
	} entry_t;

	// outcome of a scan over the directory
	typedef struct packed {
		logic hit_found;
		logic free_found;
	} scan_flags_t;

endpackage : sdle_pkg
`default_nettype wire

### design/sdle_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdle_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sdle_mem #(
	parameter int DEPTH = sdle_pkg::SLOTS_DEF,
	parameter int AW    = 4
) (
	input  wire logic            clk,
	input  wire logic            we,
	input  wire logic [AW-1:0]   waddr,
	input  wire sdle_pkg::entry_t wdata,
	input  wire logic            re,
	input  wire logic [AW-1:0]   raddr,
	output      sdle_pkg::entry_t rdata
);

	sdle_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule : sdle_mem
`default_nettype wire

### design/sdle_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdle_scan
// Walks the entries read back from the store: finds the first key match,
// the first free entry and the lowest-index entry of least activity.
// ----------------------------------------------------------------------------
module sdle_scan #(
	parameter int AW = 4
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  clear,
	input  wire logic                  rvld,
	input  wire logic [AW-1:0]         ridx,
	input  wire logic                  rvalid,
	input  wire sdle_pkg::entry_t      rdata,
	input  wire logic [31:0]           relation_id,
	input  wire logic [63:0]           group_key_hash,
	output      sdle_pkg::scan_flags_t flags,
	output      logic [AW-1:0]         hit_idx,
	output      logic [31:0]           hit_act,
	output      logic [AW-1:0]         free_idx,
	output      logic [AW-1:0]         min_idx,
	output      logic                  rel_match
);

	logic        have_q;
	logic [31:0] min_act_q;
	logic        key_match;

	assign rel_match = (rdata.relation == relation_id);
	assign key_match = rel_match && (rdata.hash == group_key_hash);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags  <= '0;
			have_q <= 1'b0;
		end else if (clear) begin
			flags  <= '0;
			have_q <= 1'b0;
		end else if (rvld) begin
			if (rvalid && key_match && !flags.hit_found) begin
				flags.hit_found <= 1'b1;
			end
			if (!rvalid && !flags.free_found) begin
				flags.free_found <= 1'b1;
			end
			if (rvalid && (!have_q || rdata.activity < min_act_q)) begin
				have_q <= 1'b1;
			end
		end
	end

	// payload: no reset needed
	always_ff @(posedge clk) begin
		if (rvld && !clear) begin
			if (rvalid && key_match && !flags.hit_found) begin
				hit_idx <= ridx;
				hit_act <= rdata.activity;
			end
			if (!rvalid && !flags.free_found) begin
				free_idx <= ridx;
			end
			if (rvalid && (!have_q || rdata.activity < min_act_q)) begin
				min_idx   <= ridx;
				min_act_q <= rdata.activity;
			end
		end
	end

endmodule : sdle_scan
`default_nettype wire

### design/slot_directory_least_active_evict.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slot_directory_least_active_evict
// Fully associative slot directory keyed by relation id and group hash, with
// least-active replacement and relation-wide invalidate.
// ----------------------------------------------------------------------------
// Each transaction holds busy while the single read port of the entry store
// visits every entry once, the read data landing a register later; then the
// FIN state decides and, for a lookup, writes back. The result is strobed on
// done for one cycle, in the cycle in which busy falls; the receiver cannot
// stall, so capture result whenever done is high. A new transaction may start
// in the same cycle as done. Valid bits sit in flip-flops cleared by reset, so
// the block is ready straight out of reset with no clearing pass.
// ----------------------------------------------------------------------------
module slot_directory_least_active_evict #(
	parameter int SLOTS = sdle_pkg::SLOTS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output      logic          busy,
	input  wire sdle_pkg::in_t cmd,
	output      logic          done,
	output      sdle_pkg::out_t result
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]       state_q;
	logic             issue_q;
	logic [IW-1:0]    addr_q;
	logic             rvld_s1;
	logic [IW-1:0]    ridx_s1;
	logic [SLOTS-1:0] valid_q;
	logic [CW-1:0]    count_q;
	logic [31:0]      hits_q;
	logic [31:0]      misses_q;
	logic [31:0]      evicts_q;
	sdle_pkg::in_t    cmd_q;
	logic             done_q;
	sdle_pkg::out_t   res_q;

	logic                  accept;
	logic                  rd_en;
	logic                  inv_clr;
	logic                  fin_lookup;
	logic [IW-1:0]         victim;
	logic [IW-1:0]         wr_idx;
	sdle_pkg::entry_t      wr_entry;
	logic [CW-1:0]         count_nxt;
	sdle_pkg::entry_t      rdata;
	sdle_pkg::scan_flags_t flags;
	logic [IW-1:0]         hit_idx;
	logic [31:0]           hit_act;
	logic [IW-1:0]         free_idx;
	logic [IW-1:0]         min_idx;
	logic                  rel_match;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign rd_en  = (state_q == ST_SCAN) && issue_q;
	assign done   = done_q;
	assign result = res_q;

	// ---- sequencer: accept, sweep the store, decide ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			issue_q <= 1'b0;
			addr_q  <= '0;
			rvld_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			rvld_s1 <= rd_en;
			done_q  <= (state_q == ST_FIN);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN;
						issue_q <= 1'b1;
						addr_q  <= '0;
					end
				end
				ST_SCAN: begin
					// advance the read address until the last entry is issued
					if (issue_q) begin
						if (addr_q == LAST_IDX) begin
							issue_q <= 1'b0;
						end else begin
							addr_q <= addr_q + 1'b1;
						end
					end
					// last read data lands: move on to the decision
					if (rvld_s1 && ridx_s1 == LAST_IDX) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		ridx_s1 <= addr_q;
		if (accept) begin
			cmd_q <= cmd;
		end
	end

	// ---- entry store and scan ----
	sdle_mem #(
		.DEPTH (SLOTS),
		.AW    (IW)
	) u_mem (
		.clk   (clk),
		.we    (fin_lookup),
		.waddr (wr_idx),
		.wdata (wr_entry),
		.re    (rd_en),
		.raddr (addr_q),
		.rdata (rdata)
	);

	sdle_scan #(
		.AW (IW)
	) u_scan (
		.clk            (clk),
		.arst_n         (arst_n),
		.clear          (accept),
		.rvld           (rvld_s1),
		.ridx           (ridx_s1),
		.rvalid         (valid_q[ridx_s1]),
		.rdata          (rdata),
		.relation_id    (cmd_q.relation_id),
		.group_key_hash (cmd_q.group_key_hash),
		.flags          (flags),
		.hit_idx        (hit_idx),
		.hit_act        (hit_act),
		.free_idx       (free_idx),
		.min_idx        (min_idx),
		.rel_match      (rel_match)
	);

	// ---- decision ----
	// Drop an entry of the relation as it streams past during an invalidate.
	assign inv_clr = rvld_s1 && (cmd_q.func == sdle_pkg::FUNC_INVALIDATE)
		&& valid_q[ridx_s1] && rel_match;

	assign fin_lookup = (state_q == ST_FIN) && (cmd_q.func == sdle_pkg::FUNC_LOOKUP);

	// First free entry wins; otherwise the lowest-index least-active one.
	assign victim = flags.free_found ? free_idx : min_idx;
	assign wr_idx = flags.hit_found ? hit_idx : victim;

	always_comb begin
		wr_entry.relation = cmd_q.relation_id;
		wr_entry.hash     = cmd_q.group_key_hash;
		if (flags.hit_found) begin
			wr_entry.activity = (hit_act == '1) ? hit_act : hit_act + 32'd1;
		end else begin
			wr_entry.activity = 32'd1;
		end
	end

	// occupancy grows only when a miss takes a free entry
	assign count_nxt = (fin_lookup && !flags.hit_found && flags.free_found)
		? count_q + 1'b1 : count_q;

	// ---- valid bits, occupancy and totals ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			count_q  <= '0;
			hits_q   <= '0;
			misses_q <= '0;
			evicts_q <= '0;
		end else begin
			if (inv_clr) begin
				valid_q[ridx_s1] <= 1'b0;
				count_q          <= count_q - 1'b1;
			end
			if (fin_lookup) begin
				count_q <= count_nxt;
				if (flags.hit_found) begin
					if (hits_q != '1) begin
						hits_q <= hits_q + 32'd1;
					end
				end else begin
					valid_q[victim] <= 1'b1;
					if (misses_q != '1) begin
						misses_q <= misses_q + 32'd1;
					end
					if (!flags.free_found && evicts_q != '1) begin
						evicts_q <= evicts_q + 32'd1;
					end
				end
			end
		end
	end

	// ---- result register: hold until the next decision ----
	always_ff @(posedge clk) begin
		if (state_q == ST_FIN) begin
			res_q.occupancy <= 5'(count_nxt);
			if (cmd_q.func == sdle_pkg::FUNC_LOOKUP) begin
				res_q.slot_index <= 4'(wr_idx);
				res_q.hit        <= flags.hit_found;
				res_q.is_new     <= !flags.hit_found;
				res_q.evicted    <= !flags.hit_found && !flags.free_found;
				res_q.hit_total  <= (flags.hit_found && hits_q != '1)
					? hits_q + 32'd1 : hits_q;
				res_q.miss_total <= (!flags.hit_found && misses_q != '1)
					? misses_q + 32'd1 : misses_q;
				res_q.eviction_total <= (!flags.hit_found && !flags.free_found
					&& evicts_q != '1) ? evicts_q + 32'd1 : evicts_q;
			end else begin
				res_q.slot_index     <= '0;
				res_q.hit            <= 1'b0;
				res_q.is_new         <= 1'b0;
				res_q.evicted        <= 1'b0;
				res_q.hit_total      <= hits_q;
				res_q.miss_total     <= misses_q;
				res_q.eviction_total <= evicts_q;
			end
		end
	end

endmodule : slot_directory_least_active_evict
`default_nettype wire

### design/sdle_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdle_chk
// Port-level checks on transaction flow and result flags.
// ----------------------------------------------------------------------------
module sdle_chk (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           start,
	input wire logic           busy,
	input wire logic           done,
	input wire sdle_pkg::out_t result
);

	// an accepted transaction holds the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not raise busy");

	// the end of a transaction is followed by its result
	a_fell_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result strobe");

	// one strobe per transaction
	a_single_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe repeated");

	// a hit neither allocates nor evicts
	a_hit_flags: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.hit |-> !result.is_new && !result.evicted)
		else $error("hit reported with allocation flags");

	// an eviction only happens on a fresh allocation
	a_evict_new: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.evicted |-> result.is_new)
		else $error("eviction without allocation");

endmodule : sdle_chk

bind slot_directory_least_active_evict sdle_chk u_sdle_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the slot directory with least-active eviction. A
// short table of directed transactions covers reset state, key extremes,
// invalidate of present and absent relations, a full directory and eviction.
// Random transactions over a small key pool then drive hits, misses,
// evictions and invalidates. Every result is checked field by field against
// a typed expectation or an in-bench model of the directory.
// ----------------------------------------------------------------------------
module testbench;

	localparam int SLOTS       = sdle_pkg::SLOTS_DEF;
	localparam int RAND_ITEMS  = 400;
	localparam int STALL_LIMIT = 50 * (SLOTS + 2);

	logic           clk;
	logic           arst_n;
	logic           start;
	logic           busy;
	sdle_pkg::in_t  cmd;
	logic           done;
	sdle_pkg::out_t result;

	slot_directory_least_active_evict #(.SLOTS(SLOTS)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	// ------------------------------------------------------------------------
	// Directory model: own copy of every entry and of the three totals
	// ------------------------------------------------------------------------
	logic        dir_valid [SLOTS];
	logic [31:0] dir_rel   [SLOTS];
	logic [63:0] dir_hash  [SLOTS];
	logic [31:0] dir_act   [SLOTS];
	logic [31:0] tot_hits;
	logic [31:0] tot_misses;
	logic [31:0] tot_evicts;
	int          n_invalidates;

	// results still owed by the block, oldest first
	sdle_pkg::out_t pending_results[$];
	int   err_count;
	int   sent_count;
	int   checked_count;

	// one row of the directed table
	typedef struct {
		sdle_pkg::in_t  cmd;
		bit             typed;
		sdle_pkg::out_t want;
	} dir_row_t;

	dir_row_t directed_rows[$];

	function automatic logic [31:0] sat_bump(input logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	// Apply one transaction to the model and return the result it owes.
	function automatic sdle_pkg::out_t directory_lookup(input sdle_pkg::in_t c);
		sdle_pkg::out_t r;
		int   victim;
		int   count;
		bit   found;
		r     = '0;
		found = 1'b0;
		if (c.func == sdle_pkg::FUNC_INVALIDATE) begin
			n_invalidates++;
			for (int i = 0; i < SLOTS; i++)
				if (dir_valid[i] && dir_rel[i] == c.relation_id)
					dir_valid[i] = 1'b0;
		end else begin
			// hit: first valid entry holding the full key
			for (int i = 0; i < SLOTS && !found; i++) begin
				if (dir_valid[i] && dir_rel[i] == c.relation_id &&
				    dir_hash[i] == c.group_key_hash) begin
					dir_act[i]   = sat_bump(dir_act[i]);
					tot_hits     = sat_bump(tot_hits);
					r.slot_index = i[3:0];
					r.hit        = 1'b1;
					found        = 1'b1;
				end
			end
			if (!found) begin
				tot_misses = sat_bump(tot_misses);
				// victim: first free entry, else lowest index of least activity
				victim = -1;
				for (int i = 0; i < SLOTS && victim < 0; i++)
					if (!dir_valid[i])
						victim = i;
				if (victim < 0) begin
					victim = 0;
					for (int i = 1; i < SLOTS; i++)
						if (dir_act[i] < dir_act[victim])
							victim = i;
					tot_evicts = sat_bump(tot_evicts);
					r.evicted  = 1'b1;
				end
				dir_valid[victim] = 1'b1;
				dir_rel[victim]   = c.relation_id;
				dir_hash[victim]  = c.group_key_hash;
				dir_act[victim]   = 32'd1;
				r.slot_index      = victim[3:0];
				r.is_new          = 1'b1;
			end
		end
		count = 0;
		for (int i = 0; i < SLOTS; i++)
			if (dir_valid[i])
				count++;
		r.occupancy      = count[4:0];
		r.hit_total      = tot_hits;
		r.miss_total     = tot_misses;
		r.eviction_total = tot_evicts;
		return r;
	endfunction

	// Build a typed expectation for the directed table.
	function automatic sdle_pkg::out_t make_result(input int slot, input bit fresh,
		input bit hit, input bit ev, input int in_use, input int h, input int m,
		input int e);
		sdle_pkg::out_t r;
		r.slot_index     = slot[3:0];
		r.is_new         = fresh;
		r.hit            = hit;
		r.evicted        = ev;
		r.occupancy      = in_use[4:0];
		r.hit_total      = h;
		r.miss_total     = m;
		r.eviction_total = e;
		return r;
	endfunction

	task automatic add_row(input logic f, input logic [31:0] rel, input logic [63:0] hash,
		input bit typed, input sdle_pkg::out_t want);
		dir_row_t row;
		row.cmd.func           = f;
		row.cmd.relation_id    = rel;
		row.cmd.group_key_hash = hash;
		row.typed              = typed;
		row.want               = want;
		directed_rows.push_back(row);
	endtask

	task automatic flag_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		err_count++;
		$display("MISMATCH t=%0t result %0d %s: got %0h want %0h",
			$time, checked_count, what, got, want);
	endtask

	// ------------------------------------------------------------------------
	// Clock and reset
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Result checker: the block strobes done for one cycle and cannot be held
	// off, so sample at every rising edge and compare with the oldest
	// outstanding expectation.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		sdle_pkg::out_t exp_res;
		if (arst_n && done === 1'b1) begin
			if (pending_results.size() == 0) begin
				flag_mismatch("strobe with no transaction outstanding", 64'd1, 64'd0);
			end else begin
				exp_res = pending_results.pop_front();
				if (result.slot_index !== exp_res.slot_index)
					flag_mismatch("slot_index", 64'(result.slot_index),
						64'(exp_res.slot_index));
				if (result.is_new !== exp_res.is_new)
					flag_mismatch("is_new", 64'(result.is_new), 64'(exp_res.is_new));
				if (result.hit !== exp_res.hit)
					flag_mismatch("hit", 64'(result.hit), 64'(exp_res.hit));
				if (result.evicted !== exp_res.evicted)
					flag_mismatch("evicted", 64'(result.evicted), 64'(exp_res.evicted));
				if (result.occupancy !== exp_res.occupancy)
					flag_mismatch("occupancy", 64'(result.occupancy),
						64'(exp_res.occupancy));
				if (result.hit_total !== exp_res.hit_total)
					flag_mismatch("hit_total", 64'(result.hit_total),
						64'(exp_res.hit_total));
				if (result.miss_total !== exp_res.miss_total)
					flag_mismatch("miss_total", 64'(result.miss_total),
						64'(exp_res.miss_total));
				if (result.eviction_total !== exp_res.eviction_total)
					flag_mismatch("eviction_total", 64'(result.eviction_total),
						64'(exp_res.eviction_total));
				checked_count++;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: count cycles in which neither a command nor a result moves
	// ------------------------------------------------------------------------
	int idle_cycles;

	always @(posedge clk) begin
		if (!arst_n || (start === 1'b1 && busy === 1'b0) || done === 1'b1)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
				idle_cycles, pending_results.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Command driver
	// ------------------------------------------------------------------------
	bit eager;   // when set, hold start high back to back with no gaps

	// Offer one command after a random gap (none when eager is set) and wait for
	// the block to take it. On acceptance, advance the model; queue the typed
	// expectation where the row has one, otherwise the model's own result.
	task automatic issue(input sdle_pkg::in_t c, input bit typed,
		input sdle_pkg::out_t want);
		int   gap;
		sdle_pkg::out_t model_res;
		gap = eager ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		model_res = directory_lookup(c);
		pending_results.push_back(typed ? want : model_res);
		sent_count++;
	endtask

	initial begin
		logic [31:0]   rel_pool  [4];
		logic [63:0]   hash_pool [6];
		logic [31:0]   rel_a;
		sdle_pkg::in_t c;
		int            pick;

		start         = 1'b0;
		cmd           = '0;
		arst_n        = 1'b0;
		err_count     = 0;
		sent_count    = 0;
		checked_count = 0;
		n_invalidates = 0;
		eager         = 1'b0;
		tot_hits      = '0;
		tot_misses    = '0;
		tot_evicts    = '0;
		for (int i = 0; i < SLOTS; i++) begin
			dir_valid[i] = 1'b0;
			dir_rel[i]   = '0;
			dir_hash[i]  = '0;
			dir_act[i]   = '0;
		end

		// Directed table. Typed rows are the ones readable straight off the
		// directory rules: first allocation after reset, a plain hit, the
		// all-ones key, invalidate of an absent and of a present relation.
		rel_a = 32'hA5A5_0001;
		add_row(sdle_pkg::FUNC_LOOKUP, 32'h0, 64'h0, 1'b1,
			make_result(0, 1, 0, 0, 1, 0, 1, 0));
		add_row(sdle_pkg::FUNC_LOOKUP, 32'h0, 64'h0, 1'b1,
			make_result(0, 0, 1, 0, 1, 1, 1, 0));
		add_row(sdle_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
			make_result(1, 1, 0, 0, 2, 1, 2, 0));
		add_row(sdle_pkg::FUNC_INVALIDATE, 32'h0000_1234, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
			make_result(0, 0, 0, 0, 2, 1, 2, 0));
		add_row(sdle_pkg::FUNC_INVALIDATE, 32'h0, 64'h0, 1'b1,
			make_result(0, 0, 0, 0, 1, 1, 2, 0));
		add_row(sdle_pkg::FUNC_LOOKUP, 32'h0, 64'h0, 1'b1,
			make_result(0, 1, 0, 0, 2, 1, 3, 0));
		// fill the remaining slots so the directory is full
		for (int k = 1; k <= SLOTS - 2; k++)
			add_row(sdle_pkg::FUNC_LOOKUP, rel_a, 64'(k), 1'b0, '0);
		// raise activity on slots 0 and 1, then force evictions of the
		// least active, including keys that differ in one part only
		add_row(sdle_pkg::FUNC_LOOKUP, 32'h0, 64'h0, 1'b0, '0);
		add_row(sdle_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0);
		add_row(sdle_pkg::FUNC_LOOKUP, 32'h0, 64'h1, 1'b0, '0);
		add_row(sdle_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, 64'h0, 1'b0, '0);
		add_row(sdle_pkg::FUNC_INVALIDATE, rel_a, 64'h0, 1'b0, '0);

		// hold reset, then release it on a clock edge
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			issue(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);

		// Random part: keys mostly from a small pool (more keys than slots,
		// so hits, misses and evictions all occur), with occasional
		// full-range keys to toggle every bit.
		foreach (rel_pool[i])
			rel_pool[i] = $urandom;
		rel_pool[0] = 32'h0;
		rel_pool[3] = 32'hFFFF_FFFF;
		foreach (hash_pool[i])
			hash_pool[i] = {$urandom, $urandom};
		hash_pool[0] = 64'h0;
		hash_pool[5] = 64'hFFFF_FFFF_FFFF_FFFF;

		for (int n = 0; n < RAND_ITEMS; n++) begin
			// alternate stretches with random gaps and back-to-back commands
			eager = ((n / 50) % 3) == 2;
			pick  = $urandom_range(0, 99);
			if (pick < 8) begin
				// invalidate a pool relation, now and then an absent one
				c.func           = sdle_pkg::FUNC_INVALIDATE;
				c.relation_id    = ($urandom_range(0, 3) == 0) ? 32'($urandom)
				                   : rel_pool[$urandom_range(0, 3)];
				c.group_key_hash = {$urandom, $urandom};
			end else if (pick < 88) begin
				c.func           = sdle_pkg::FUNC_LOOKUP;
				c.relation_id    = rel_pool[$urandom_range(0, 3)];
				c.group_key_hash = hash_pool[$urandom_range(0, 5)];
			end else begin
				c.func           = sdle_pkg::FUNC_LOOKUP;
				c.relation_id    = $urandom;
				c.group_key_hash = {$urandom, $urandom};
			end
			issue(c, 1'b0, '0);
		end
		start <= 1'b0;

		// drain outstanding results, then allow one more transaction time
		// for anything stray the block might still strobe
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SLOTS + 4) @(posedge clk);

		$display("Sent %0d transactions, checked %0d results", sent_count, checked_count);
		$display("Directory saw %0d hits, %0d misses, %0d evictions, %0d invalidates",
			tot_hits, tot_misses, tot_evicts, n_invalidates);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
